FILE: rtl/lrd_pkg.sv
// Shared types, constants and microcode encodings for the line rasterizer.
// Used by the sequencer, the serial divider and the top level; no dependencies.
`default_nettype none
package lrd_pkg;

    localparam int SCREEN_WIDTH  = 32;
    localparam int SCREEN_HEIGHT = 32;

    localparam int COORD_W = 5;
    localparam int COLOR_W = 24;
    localparam int OFFS_W  = 21;
    localparam int BPP_W   = 3;
    localparam int STRD_W  = 16;
    localparam int NUM_W   = 2 * COORD_W;
    localparam int DEN_W   = COORD_W;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int UPC_W   = 4;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register word indexes (byte address / 4)
    localparam logic REG_BPP    = 1'b0;
    localparam logic REG_STRIDE = 1'b1;

    // datapath operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_INIT = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_EMIT = 3'd5;
    localparam logic [2:0] OP_SWAP = 3'd6;

    // jump conditions
    localparam logic [2:0] C_NEVER    = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_NO_INPUT = 3'd2;
    localparam logic [2:0] C_SKIP_ROW = 3'd3;
    localparam logic [2:0] C_DIV_MORE = 3'd4;
    localparam logic [2:0] C_OUT_FULL = 3'd5;
    localparam logic [2:0] C_MORE     = 3'd6;
    localparam logic [2:0] C_X_EQUAL  = 3'd7;

    localparam logic PASS_ROW = 1'b0;
    localparam logic PASS_COL = 1'b1;

    typedef struct packed {
        logic [2:0]       op;
        logic             pass;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_input;
        logic skip_row;
        logic div_more;
        logic out_full;
        logic more;
        logic x_equal;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/lrd_ucode_seq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on lrd_pkg for the control word and status encodings.
`default_nettype none
module lrd_ucode_seq
    import lrd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_status_t status,
    output ctrl_word_t      ctrl
);

    // step addresses of the program
    localparam logic [UPC_W-1:0] A_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] A_ROWM  = 4'd2;
    localparam logic [UPC_W-1:0] A_ROWD  = 4'd3;
    localparam logic [UPC_W-1:0] A_ROWW  = 4'd4;
    localparam logic [UPC_W-1:0] A_SWAP  = 4'd6;
    localparam logic [UPC_W-1:0] A_COLM  = 4'd7;
    localparam logic [UPC_W-1:0] A_COLD  = 4'd8;
    localparam logic [UPC_W-1:0] A_COLW  = 4'd9;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take_jump;

    function automatic ctrl_word_t uw(input logic [2:0] op, input logic pass,
                                      input logic [2:0] cond,
                                      input logic [UPC_W-1:0] target);
        ctrl_word_t w;
        w.op     = op;
        w.pass   = pass;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    always_comb begin
        case (upc_reg)
            4'd0:    ctrl = uw(OP_LOAD, PASS_ROW, C_NO_INPUT, A_IDLE);
            4'd1:    ctrl = uw(OP_INIT, PASS_ROW, C_SKIP_ROW, A_SWAP);
            4'd2:    ctrl = uw(OP_MUL,  PASS_ROW, C_NEVER,    A_IDLE);
            4'd3:    ctrl = uw(OP_DIV,  PASS_ROW, C_DIV_MORE, A_ROWD);
            4'd4:    ctrl = uw(OP_NOP,  PASS_ROW, C_OUT_FULL, A_ROWW);
            4'd5:    ctrl = uw(OP_EMIT, PASS_ROW, C_MORE,     A_ROWM);
            4'd6:    ctrl = uw(OP_SWAP, PASS_COL, C_X_EQUAL,  A_IDLE);
            4'd7:    ctrl = uw(OP_MUL,  PASS_COL, C_NEVER,    A_IDLE);
            4'd8:    ctrl = uw(OP_DIV,  PASS_COL, C_DIV_MORE, A_COLD);
            4'd9:    ctrl = uw(OP_NOP,  PASS_COL, C_OUT_FULL, A_COLW);
            4'd10:   ctrl = uw(OP_EMIT, PASS_COL, C_MORE,     A_COLM);
            default: ctrl = uw(OP_NOP,  PASS_ROW, C_ALWAYS,   A_IDLE);
        endcase
    end

    always_comb begin
        case (ctrl.cond)
            C_NEVER:    take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_NO_INPUT: take_jump = status.no_input;
            C_SKIP_ROW: take_jump = status.skip_row;
            C_DIV_MORE: take_jump = status.div_more;
            C_OUT_FULL: take_jump = status.out_full;
            C_MORE:     take_jump = status.more;
            C_X_EQUAL:  take_jump = status.x_equal;
            default:    take_jump = 1'b0;
        endcase
        upc_next = take_jump ? ctrl.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= A_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lrd_serial_div.sv
// Restoring unsigned divider, one quotient bit per step.
// Depends on lrd_pkg for operand widths.
`default_nettype none
module lrd_serial_div
    import lrd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic             step,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output logic                  more
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        fits     = shifted >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start) begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = num;
        end else if (step) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
            quo_next = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign more = cnt_reg != CNT_W'(1);

endmodule
`default_nettype wire

FILE: rtl/line_rasterizer_divide_unit.sv
// Line rasterizer: microcoded sequencer driving a coordinate datapath, a
// shared serial divider, an APB register file and a registered output beat.
// Per pixel the program runs a multiply, 10 divide steps, an output check that
// waits while the output beat is untaken, and an emit; the serial divider sets
// the number of divide steps. The next line is taken once the last pixel is emitted.
// Synchronous active-low reset returns to idle and restores bpp 4, stride 128.
`default_nettype none
module line_rasterizer_divide_unit
    import lrd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // start_x, start_y, end_x, end_y, line_color (lowest bit up), zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // pixel_x, pixel_y, byte_offset, pixel_color (lowest bit up), zero pad
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tvalid,
    output logic                     m_tlast,
    input  wire logic                m_tready,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready
);

    ctrl_word_t ctrl;
    dp_status_t status;

    logic [BPP_W-1:0]  bpp_reg;
    logic [STRD_W-1:0] stride_reg;

    logic [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cur_reg;
    logic [COORD_W-1:0] ax_next, ay_next, bx_next, by_next, cur_next;
    logic [COLOR_W-1:0] color_reg;
    logic               neg_reg;

    logic [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
    logic signed [COORD_W:0] span, delta, den_s;
    logic [COORD_W-1:0] span_mag, delta_mag, den_mag;
    logic [NUM_W-1:0]   prod;
    logic [DEN_W-1:0]   div_den;
    logic [NUM_W-1:0]   div_quo;
    logic               div_more;
    logic               div_start, div_step;

    logic signed [COORD_W:0]   q_signed;
    logic [COORD_W+1:0]        coord_sum;
    logic [COORD_W-1:0]        base, px, py, end_coord;
    logic [COORD_W+BPP_W-1:0]  x_part;
    logic [COORD_W+STRD_W-1:0] y_part;
    logic                      last;
    logic                      emit;

    logic               m_tvalid_reg;
    logic               m_tlast_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [OFFS_W-1:0]  out_off_reg;
    logic [COLOR_W-1:0] out_color_reg;

    logic cfg_wr;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v,
                                                     input int limit);
        logic [COORD_W-1:0] top;
        top = COORD_W'(limit - 1);
        return ({1'b0, v} > {1'b0, top}) ? top : v;
    endfunction

    function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W:0] v);
        return v[COORD_W] ? COORD_W'(-v) : v[COORD_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= BPP_W'(4);
            stride_reg <= STRD_W'(128);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_BPP:    bpp_reg    <= pwdata[BPP_W-1:0];
                REG_STRIDE: stride_reg <= pwdata[STRD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BPP:    prdata = {{(APB_DW-BPP_W){1'b0}}, bpp_reg};
            REG_STRIDE: prdata = {{(APB_DW-STRD_W){1'b0}}, stride_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer and divider ----------------
    lrd_ucode_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign div_start = ctrl.op == OP_MUL;
    assign div_step  = ctrl.op == OP_DIV;

    lrd_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .step    (div_step),
        .num     (prod),
        .den     (div_den),
        .quo     (div_quo),
        .more    (div_more)
    );

    // ---------------- datapath ----------------
    assign s_tready = ctrl.op == OP_LOAD;
    assign emit     = ctrl.op == OP_EMIT;

    assign in_sx = sat_coord(s_tdata[4:0],   SCREEN_WIDTH);
    assign in_sy = sat_coord(s_tdata[9:5],   SCREEN_HEIGHT);
    assign in_ex = sat_coord(s_tdata[14:10], SCREEN_WIDTH);
    assign in_ey = sat_coord(s_tdata[19:15], SCREEN_HEIGHT);

    always_comb begin
        if (ctrl.pass == PASS_COL) begin
            span  = $signed({1'b0, by_reg}) - $signed({1'b0, ay_reg});
            delta = $signed({1'b0, cur_reg}) - $signed({1'b0, ax_reg});
            den_s = $signed({1'b0, bx_reg}) - $signed({1'b0, ax_reg});
            base  = ay_reg;
            end_coord = bx_reg;
        end else begin
            span  = $signed({1'b0, bx_reg}) - $signed({1'b0, ax_reg});
            delta = $signed({1'b0, cur_reg}) - $signed({1'b0, ay_reg});
            den_s = $signed({1'b0, by_reg}) - $signed({1'b0, ay_reg});
            base  = ax_reg;
            end_coord = by_reg;
        end
        span_mag  = mag(span);
        delta_mag = mag(delta);
        den_mag   = mag(den_s);
        prod      = NUM_W'(span_mag) * NUM_W'(delta_mag);
        div_den   = (den_mag == '0) ? DEN_W'(1) : den_mag;

        q_signed  = neg_reg ? -$signed({1'b0, div_quo[COORD_W-1:0]})
                            :  $signed({1'b0, div_quo[COORD_W-1:0]});
        coord_sum = {2'b00, base} + {q_signed[COORD_W], q_signed};
        px = (ctrl.pass == PASS_COL) ? cur_reg : coord_sum[COORD_W-1:0];
        py = (ctrl.pass == PASS_COL) ? coord_sum[COORD_W-1:0] : cur_reg;
        x_part = (COORD_W+BPP_W)'(px) * (COORD_W+BPP_W)'(bpp_reg);
        y_part = (COORD_W+STRD_W)'(py) * (COORD_W+STRD_W)'(stride_reg);
        last = (ctrl.pass == PASS_COL) ? (cur_reg == bx_reg)
                                       : (cur_reg == by_reg) && (ax_reg == bx_reg);
    end

    always_comb begin
        ax_next  = ax_reg;
        ay_next  = ay_reg;
        bx_next  = bx_reg;
        by_next  = by_reg;
        cur_next = cur_reg;
        case (ctrl.op)
            OP_LOAD: begin
                // start takes the larger y
                if (in_sy < in_ey) begin
                    ax_next = in_ex; ay_next = in_ey;
                    bx_next = in_sx; by_next = in_sy;
                end else begin
                    ax_next = in_sx; ay_next = in_sy;
                    bx_next = in_ex; by_next = in_ey;
                end
            end
            OP_INIT: cur_next = ay_reg;
            OP_EMIT: cur_next = (ctrl.pass == PASS_COL) ? cur_reg + 1'b1 : cur_reg - 1'b1;
            OP_SWAP: begin
                // reorder by x, then walk the columns after the start
                if (ax_reg > bx_reg) begin
                    ax_next = bx_reg; ay_next = by_reg;
                    bx_next = ax_reg; by_next = ay_reg;
                    cur_next = bx_reg + 1'b1;
                end else begin
                    cur_next = ax_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op != OP_LOAD || s_tvalid) begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            bx_reg <= bx_next;
            by_reg <= by_next;
        end
        cur_reg <= cur_next;
        if (s_tvalid && s_tready) begin
            color_reg <= s_tdata[43:20];
        end
        if (ctrl.op == OP_MUL) begin
            neg_reg <= span[COORD_W] ^ delta[COORD_W] ^ den_s[COORD_W];
        end
    end

    assign status.no_input = !s_tvalid;
    assign status.skip_row = ($signed({1'b0, bx_reg}) - $signed({1'b0, ax_reg}))
                           < ($signed({1'b0, by_reg}) - $signed({1'b0, ay_reg}));
    assign status.div_more = div_more;
    assign status.out_full = m_tvalid_reg && !m_tready;
    assign status.more     = cur_reg != end_coord;
    assign status.x_equal  = ax_reg == bx_reg;

    // ---------------- output beat ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg     <= px;
            out_y_reg     <= py;
            out_off_reg   <= OFFS_W'({1'b0, y_part} + (COORD_W+STRD_W+1)'(x_part));
            out_color_reg <= color_reg;
            m_tlast_reg   <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(M_DATA_W-2*COORD_W-OFFS_W-COLOR_W){1'b0}},
                       out_color_reg, out_off_reg, out_y_reg, out_x_reg};

    // ---------------- assertions ----------------
    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !m_tvalid_reg)
        else $error("pixel emitted over an untaken beat");

    a_div_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_MUL) |=> (ctrl.op == OP_DIV) && div_more)
        else $error("divide steps do not follow operand setup");

    a_load_then_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (ctrl.op == OP_INIT) && !s_tready)
        else $error("accepted line not followed by setup");

endmodule
`default_nettype wire
